// File: rtl/mcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants of the modified clock replacement block.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int WS_DEPTH    = 32;
  localparam int PAGE_BITS   = 20;
  localparam int IDX_W       = $clog2(WS_DEPTH);
  localparam int CNT_W       = $clog2(WS_DEPTH + 1);
  localparam int CFG_W       = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_PAGE_W   = 20;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CFG_W-1:0] WS_SIZE_RESET = CFG_W'(32);

  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_FAULT  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [PAGE_BITS-1:0] page;
    logic                 wr;
  } item_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic        victim_modified;
    logic [19:0] victim_page;
    logic        victim_valid;
    logic [4:0]  slot_index;
    logic        resident;
  } res_t;

  function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] s;
    if (v == '0) begin
      s = CNT_W'(1);
    end else if (int'(v) > WS_DEPTH) begin
      s = CNT_W'(WS_DEPTH);
    end else begin
      s = CNT_W'(v);
    end
    return s;
  endfunction

endpackage

// File: rtl/mcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_front
// Input stage: takes words, decodes the kind and the page, holds one item.
// ----------------------------------------------------------------------------
module mcr_front import mcr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // page_number[19:0], is_write, zero pad
  input  logic                  s_tuser,   // mode
  output logic                  item_valid,
  input  logic                  item_ready,
  output item_t                 item
);

  item_t decoded;

  assign s_tready = !item_valid || item_ready;

  always_comb begin
    decoded.op   = s_tuser ? OP_FAULT : OP_ACCESS;
    decoded.page = PAGE_BITS'(s_tdata[IN_PAGE_W-1:0]);
    decoded.wr   = s_tdata[IN_PAGE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        item_valid <= 1'b1;
        item       <= decoded;
      end else if (item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/mcr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_queue
// Short item queue between the input stage and the replacement engine.
// ----------------------------------------------------------------------------
module mcr_queue import mcr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = count != QCNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= in_item;
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/mcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_back
// Replacement engine: slot lookup, clock victim search, placement, result.
// ----------------------------------------------------------------------------
module mcr_back import mcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CFG_W-1:0]       ws_max_size,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_LRD, S_LCMP, S_SEARCH, S_VRD, S_PLACE, S_EMIT
  } state_t;

  state_t                state;
  item_t                 cur;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      lap;
  logic [IDX_W-1:0]      slot;
  logic [IDX_W-1:0]      hand;
  logic [CNT_W-1:0]      fill;
  logic                  pass_odd;
  logic [WS_DEPTH-1:0]   valid;
  logic [WS_DEPTH-1:0]   used;
  logic [WS_DEPTH-1:0]   modif;
  res_t                  res;
  res_t                  res_out;

  logic [PAGE_BITS-1:0]  page_mem [WS_DEPTH];
  logic [PAGE_BITS-1:0]  rd_data;
  logic [IDX_W-1:0]      rd_addr;
  logic                  rd_en;
  logic                  wr_en;

  logic [CNT_W-1:0]      size;
  logic [IDX_W-1:0]      hand_norm;
  logic                  idx_last;
  logic                  lap_last;
  logic [IDX_W-1:0]      idx_next;
  logic [IDX_W-1:0]      slot_next;
  logic                  clean;

  function automatic res_t make_res(input logic                 hit,
                                    input logic [IDX_W-1:0]     s,
                                    input logic                 vv,
                                    input logic [PAGE_BITS-1:0] vp,
                                    input logic                 vm);
    res_t r;
    r                 = '0;
    r.resident        = hit;
    r.slot_index      = 5'(s);
    r.victim_valid    = vv;
    r.victim_page     = 20'(vp);
    r.victim_modified = vm;
    return r;
  endfunction

  assign size       = eff_size(ws_max_size);
  assign hand_norm  = (CNT_W'(hand) >= size) ? '0 : hand;
  assign idx_last   = (CNT_W'(idx) + CNT_W'(1'b1)) == size;
  assign lap_last   = (CNT_W'(lap) + CNT_W'(1'b1)) == size;
  assign idx_next   = idx_last ? '0 : idx + IDX_W'(1);
  assign slot_next  = ((CNT_W'(slot) + CNT_W'(1'b1)) == size) ? '0 : slot + IDX_W'(1);
  assign clean      = !valid[idx] || (!used[idx] && (pass_odd || !modif[idx]));
  assign item_ready = state == S_IDLE;
  assign m_tdata    = res_t'(res_out);

  assign rd_en   = (state == S_LRD) || (state == S_VRD);
  assign rd_addr = (state == S_VRD) ? slot : idx;
  assign wr_en   = state == S_PLACE;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= page_mem[rd_addr];
    end
    if (wr_en) begin
      page_mem[slot] <= cur.page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      valid    <= '0;
      used     <= '0;
      modif    <= '0;
      fill     <= '0;
      hand     <= '0;
      pass_odd <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            hand  <= hand_norm;
            idx   <= '0;
            state <= S_LRD;
          end
        end
        S_LRD: begin
          state <= S_LCMP;
        end
        S_LCMP: begin
          if (valid[idx] && rd_data == cur.page) begin
            used[idx] <= 1'b1;
            if (cur.wr) begin
              modif[idx] <= 1'b1;
            end
            res   <= make_res(1'b1, idx, 1'b0, '0, 1'b0);
            state <= S_EMIT;
          end else if (!idx_last) begin
            idx   <= idx + IDX_W'(1);
            state <= S_LRD;
          end else if (cur.op == OP_ACCESS) begin
            res   <= '0;
            state <= S_EMIT;
          end else if (fill >= size) begin
            idx      <= hand;
            lap      <= '0;
            pass_odd <= 1'b0;
            state    <= S_SEARCH;
          end else begin
            slot  <= hand;
            state <= S_VRD;
          end
        end
        S_SEARCH: begin
          if (clean) begin
            slot  <= idx;
            state <= S_VRD;
          end else begin
            if (pass_odd) begin
              used[idx] <= 1'b0;
            end
            idx <= idx_next;
            if (lap_last) begin
              lap      <= '0;
              pass_odd <= !pass_odd;
            end else begin
              lap <= lap + IDX_W'(1);
            end
          end
        end
        S_VRD: begin
          state <= S_PLACE;
        end
        S_PLACE: begin
          res <= make_res(1'b1, slot, valid[slot], valid[slot] ? rd_data : '0,
                          valid[slot] && modif[slot]);
          if (!valid[slot]) begin
            fill <= fill + CNT_W'(1);
          end
          valid[slot] <= 1'b1;
          used[slot]  <= 1'b1;
          modif[slot] <= cur.wr;
          hand        <= slot_next;
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            res_out  <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/modified_clock_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modified_clock_replacement
// Working-set page tracker with enhanced second-chance clock replacement.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// s_*       in         tuser: mode; tdata: page_number[19:0], is_write
// m_*       out        tdata: resident, slot_index[4:0], victim_valid,
//                             victim_page[19:0], victim_modified
// cfg_*     in         cfg_data: ws_max_size[5:0]
//
// One item is processed at a time by the engine, which takes it from the
// queue while idle. A lookup reads and then compares each slot scanned (the
// page store has a registered read port). A fault that misses reads the
// old page of the chosen slot, places the new page and loads the output
// register; when the set is full, a clock search comes first and visits at
// most three laps and one slot. Reset clears all flags, the fill count and
// the hand; the page store itself is not cleared. The input side keeps
// accepting words into a short queue while the engine is busy, until the
// queue fills, and the engine waits only when the output register is still full.
// ----------------------------------------------------------------------------
module modified_clock_replacement import mcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // page_number[19:0], is_write, zero pad
  input  logic                   s_tuser,   // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // resident, slot_index[4:0], victim_valid,
                                            // victim_page[19:0], victim_modified, zero pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic [CFG_W-1:0] ws_max_size;
  logic             f_valid;
  logic             f_ready;
  item_t            f_item;
  logic             q_valid;
  logic             q_ready;
  item_t            q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ws_max_size <= WS_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ws_max_size <= cfg_data;
    end
  end

  mcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  mcr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  mcr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ws_max_size (ws_max_size),
    .item_valid  (q_valid),
    .item_ready  (q_ready),
    .item        (q_item),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the modified clock replacement block.
// Words of access and fault traffic go in over the stream input while the
// output side stalls at random. A scoreboard keeps its own copy of the
// working set and its clock hand, works out the word that each accepted
// input must produce and checks every output word against it. The
// working-set size is rewritten between phases, including the values that
// get clamped.
// ----------------------------------------------------------------------------
module tb_top;
  import mcr_pkg::*;

  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 105;

  class clock_scoreboard;
    logic [PAGE_BITS-1:0] pages [WS_DEPTH];
    bit                   valid [WS_DEPTH];
    bit                   used [WS_DEPTH];
    bit                   dirty [WS_DEPTH];
    int                   fill;
    int                   hand;
    logic [CFG_W-1:0]     size_reg;
    res_t                 expected_words [$];
    int                   mismatches;
    int                   items;
    int                   faults;
    int                   hits;
    int                   evictions;
    int                   dirty_evictions;

    function new();
      for (int i = 0; i < WS_DEPTH; i++) begin
        pages[i] = '0;
        valid[i] = 1'b0;
        used[i]  = 1'b0;
        dirty[i] = 1'b0;
      end
      fill = 0;
      hand = 0;
      size_reg = WS_SIZE_RESET;
      mismatches = 0;
      items = 0;
      faults = 0;
      hits = 0;
      evictions = 0;
      dirty_evictions = 0;
    endfunction

    function void note_size(logic [CFG_W-1:0] v);
      size_reg = v;
    endfunction

    function int live_size();
      int s;
      s = int'(size_reg);
      if (s < 1) s = 1;
      if (s > WS_DEPTH) s = WS_DEPTH;
      return s;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Works out the word that one accepted input must produce.
    function void note_access(op_t op, logic [PAGE_BITS-1:0] pg, logic wr);
      int   size;
      int   slot;
      int   p;
      bit   found;
      bit   clean;
      res_t want;
      size = live_size();
      want = '0;
      items++;
      if (op == OP_FAULT) faults++;
      if (hand >= size) hand = 0;
      for (int i = 0; i < size; i++) begin
        if (valid[i] && pages[i] == pg) begin
          used[i] = 1'b1;
          if (wr) dirty[i] = 1'b1;
          want.resident = 1'b1;
          want.slot_index = 5'(i);
          hits++;
          expected_words.push_back(want);
          return;
        end
      end
      if (op == OP_ACCESS) begin
        expected_words.push_back(want);
        return;
      end
      slot = hand;
      found = 1'b0;
      if (fill >= size) begin
        for (int pass = 0; pass < 4 && !found; pass++) begin
          p = hand;
          for (int i = 0; i < size && !found; i++) begin
            clean = !valid[p] || (!used[p] && (pass % 2 == 1 || !dirty[p]));
            if (clean) begin
              slot = p;
              found = 1'b1;
            end else begin
              if (pass % 2 == 1) used[p] = 1'b0;
              p = (p + 1 >= size) ? 0 : p + 1;
            end
          end
        end
      end
      if (valid[slot]) begin
        want.victim_valid = 1'b1;
        want.victim_page = pages[slot];
        want.victim_modified = dirty[slot];
        evictions++;
        if (dirty[slot]) dirty_evictions++;
      end else begin
        fill++;
      end
      pages[slot] = pg;
      valid[slot] = 1'b1;
      used[slot] = 1'b1;
      dirty[slot] = wr;
      hand = (slot + 1 >= size) ? 0 : slot + 1;
      want.resident = 1'b1;
      want.slot_index = 5'(slot);
      expected_words.push_back(want);
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Output word %08h arrived with nothing expected.", got);
        end
        return;
      end
      want = expected_words.pop_front();
      if (got.resident !== want.resident || got.slot_index !== want.slot_index ||
          got.victim_valid !== want.victim_valid ||
          got.victim_page !== want.victim_page ||
          got.victim_modified !== want.victim_modified) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: expected res=%0b slot=%0d vv=%0b vp=%05h vm=%0b",
                   want.resident, want.slot_index, want.victim_valid,
                   want.victim_page, want.victim_modified);
          $display("          actual   res=%0b slot=%0d vv=%0b vp=%05h vm=%0b",
                   got.resident, got.slot_index, got.victim_valid,
                   got.victim_page, got.victim_modified);
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data;

  clock_scoreboard        sb = new();
  bit                     feed_steady;
  int                     size_writes;
  logic [PAGE_BITS-1:0]   page_pool [64];

  modified_clock_replacement dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out with %0d words still expected.", sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_word(res_t'(m_tdata));
    end
  end

  // Output back-pressure: runs of ready and stalls, now and then a long
  // stretch with no stall at all.
  initial begin
    int hold;
    int r;
    hold = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          m_tready <= 1'b1;
          hold = $urandom_range(100, 300);
        end else if (r < 55) begin
          m_tready <= 1'b1;
          hold = $urandom_range(0, 6);
        end else if (r < 92) begin
          m_tready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          m_tready <= 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (feed_steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_word(op_t op, logic [PAGE_BITS-1:0] pg, logic wr);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_TDATA_W'({wr, pg});
    do @(posedge clk); while (!s_tready);
    sb.note_access(op, pg, wr);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_size(logic [CFG_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.note_size(v);
    size_writes++;
  endtask

  initial begin
    int                   span;
    op_t                  op;
    logic [PAGE_BITS-1:0] pg;
    int                   phase_sizes [PHASES];
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    feed_steady = 1'b0;
    size_writes = 0;
    for (int i = 0; i < 64; i++) page_pool[i] = PAGE_BITS'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;
    phase_sizes = '{32, 1, 2, 0, 63, 8, 33, 31, 16, 5};
    phase_sizes[9] = $urandom_range(3, 63);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Misses, hits, writes and a fault on a resident page at full size.
    send_word(OP_ACCESS, 20'h00000, 1'b0);
    send_word(OP_FAULT,  20'h00000, 1'b0);
    send_word(OP_FAULT,  20'hFFFFF, 1'b1);
    send_word(OP_ACCESS, 20'hFFFFF, 1'b0);
    send_word(OP_ACCESS, 20'h00000, 1'b1);
    send_word(OP_FAULT,  20'h00000, 1'b0);
    send_word(OP_ACCESS, 20'h5A5A5, 1'b1);
    // Two slots, both used and dirty: the search runs all four passes.
    write_size(6'd2);
    send_word(OP_FAULT,  20'h12345, 1'b0);
    send_word(OP_FAULT,  20'h54321, 1'b1);
    send_word(OP_ACCESS, 20'h12345, 1'b0);
    send_word(OP_FAULT,  20'hA5A5A, 1'b1);
    // Size zero acts as one; the slot beyond it is not searched.
    write_size(6'd0);
    send_word(OP_FAULT,  20'hABCDE, 1'b0);
    send_word(OP_FAULT,  20'h00001, 1'b1);
    send_word(OP_ACCESS, 20'hA5A5A, 1'b0);
    // Oversized value clamps to full depth; the hand sits on a valid slot
    // while the set is not full, so that page is evicted.
    write_size(6'd63);
    send_word(OP_FAULT,  20'h0F0F0, 1'b1);
    send_word(OP_FAULT,  20'hA5A5A, 1'b0);
    send_word(OP_FAULT,  20'h33333, 1'b0);
    send_word(OP_FAULT,  20'h44444, 1'b1);
    send_word(OP_FAULT,  20'h77777, 1'b0);
    // Lower the size below the hand, then fault a page that lives beyond
    // the size so that it is placed twice; the lowest copy must win.
    write_size(6'd3);
    send_word(OP_FAULT,  20'h88888, 1'b0);
    send_word(OP_FAULT,  20'h77777, 1'b1);
    write_size(6'd32);
    send_word(OP_ACCESS, 20'h77777, 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      write_size(6'(phase_sizes[phase]));
      feed_steady = (phase % 3 == 2);
      span = sb.live_size() + 12;
      if (span > 63) span = 63;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) == 0) wait_drained();
        if ($urandom_range(0, 99) < 85) begin
          pg = page_pool[$urandom_range(0, span)];
        end else begin
          pg = PAGE_BITS'($urandom);
        end
        op = ($urandom_range(0, 99) < 40) ? OP_FAULT : OP_ACCESS;
        send_word(op, pg, 1'($urandom_range(0, 1)));
      end
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (300) @(posedge clk);
    $display("Ran %0d words (%0d faults, %0d hits) over %0d working-set sizes.",
             sb.items, sb.faults, sb.hits, size_writes + 1);
    $display("Evicted %0d pages, %0d of them dirty; %0d mismatches.",
             sb.evictions, sb.dirty_evictions, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
